@@ rtl/core/efc_pkg.sv @@
// Package with shared types and constants for the ERSPAN flow classifier.
`timescale 1ns / 1ps
`default_nettype none
package efc_pkg;
  localparam int NumRulesDef  = 2;
  localparam int MaxQueuesDef = 16;

  localparam logic [31:0] HashMul    = 32'd59;
  localparam logic [7:0]  ProtoGre   = 8'd47;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoIcmp  = 8'd1;
  localparam logic [15:0] TypeErspan = 16'h88BE;
  localparam logic [8:0]  ProtoAny   = 9'h1FF;

  localparam logic [2:0] REG_NUM_QUEUES = 3'd0;
  localparam logic [2:0] REG_RULES      = 3'd1;
  localparam logic [2:0] REG_R0_SRC     = 3'd2;
  localparam logic [2:0] REG_R0_DST     = 3'd3;
  localparam logic [2:0] REG_R0_PROTO   = 3'd4;
  localparam logic [2:0] REG_R1_SRC     = 3'd5;
  localparam logic [2:0] REG_R1_DST     = 3'd6;
  localparam logic [2:0] REG_R1_PROTO   = 3'd7;

  typedef enum logic [2:0] {
    KIND_TCP     = 3'd0,
    KIND_ICMP    = 3'd1,
    KIND_OTHER   = 3'd2,
    KIND_NOTSPAN = 3'd3,
    KIND_DROP    = 3'd4
  } kind_e;

  // Parsed packet summary handed from the parser to the back end
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] hash;
  } pkt_sum_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_MOD,
    BE_OUT
  } be_state_e;
endpackage
`default_nettype wire

@@ rtl/core/erspan_flow_classifier.sv @@
// Top level of the ERSPAN flow classifier: config registers, parser and back end.
// Frame bytes enter on the s_axis channel, one beat per byte, tlast on the final
// byte. One result leaves on m_axis per frame: kind, queue index, rule hits and
// both rule counters. The parser takes a byte every cycle while its summary slot
// has room; on the last byte it hands a summary to the back end through a
// one-entry register. The back end goes from idle straight to its output state
// on a non-TCP frame, and through a bit-serial modulo over the 32-bit hash on a
// TCP frame, then loads the output register. Frames long enough to cover the
// back end's work stream without stalls; back-to-back short frames wait on the
// back end. A stalled m_axis holds the result and the back end, and the parser
// stops taking bytes once its summary slot is full.
// Reset clears the parser state, the counters and the registers to their
// defaults (one queue, no rules, wildcard protocol).
`timescale 1ns / 1ps
`default_nettype none
module erspan_flow_classifier
  import efc_pkg::*;
#(
  parameter int NumRules  = NumRulesDef,
  parameter int MaxQueues = MaxQueuesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // packet_kind[2:0], queue_index[6:3], rule_hits[8:7], rule0_count[40:9],
  // rule1_count[72:41], zero pad
  output logic [79:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  logic [4:0]  nq_q;
  logic [1:0]  rules_q;
  logic [63:0] rsrc_q, rdst_q;
  logic [17:0] rproto_q;
  logic        sum_valid, sum_ready;
  pkt_sum_t    sum;
  logic [2:0]  kind;
  logic [3:0]  queue;
  logic [1:0]  hits;
  logic [31:0] c0, c1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nq_q <= 5'd1; rules_q <= '0; rsrc_q <= '0; rdst_q <= '0;
      rproto_q <= {ProtoAny, ProtoAny};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_QUEUES: nq_q <= cfg_data_i[4:0];
        REG_RULES:      rules_q <= cfg_data_i[1:0];
        REG_R0_SRC:     rsrc_q[31:0] <= cfg_data_i;
        REG_R0_DST:     rdst_q[31:0] <= cfg_data_i;
        REG_R0_PROTO:   rproto_q[8:0] <= cfg_data_i[8:0];
        REG_R1_SRC:     rsrc_q[63:32] <= cfg_data_i;
        REG_R1_DST:     rdst_q[63:32] <= cfg_data_i;
        REG_R1_PROTO:   rproto_q[17:9] <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  efc_parser u_parser (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .sum_valid_o(sum_valid), .sum_ready_i(sum_ready), .sum_o(sum)
  );

  efc_back #(.NumRules(NumRules), .MaxQueues(MaxQueues)) u_back (
    .clk_i, .rst_ni,
    .sum_valid_i(sum_valid), .sum_ready_o(sum_ready), .sum_i(sum),
    .num_queues_i(nq_q), .rules_i(rules_q), .rsrc_i(rsrc_q), .rdst_i(rdst_q),
    .rproto_i(rproto_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .kind_o(kind), .queue_o(queue), .hits_o(hits), .cnt0_o(c0), .cnt1_o(c1)
  );

  assign m_axis_tdata = {7'd0, c1, c0, hits, queue, kind};
endmodule
`default_nettype wire

@@ rtl/core/efc_parser.sv @@
// Byte parser: walks the frame headers and emits one summary per frame.
`timescale 1ns / 1ps
`default_nettype none
module efc_parser
  import efc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic [7:0] byte_i,
  input  wire logic     last_i,
  output logic          sum_valid_o,
  input  wire logic     sum_ready_i,
  output pkt_sum_t      sum_o
);
  logic [15:0] off_q;
  logic [5:0]  ohl_q, ihl_q;
  logic [7:0]  oproto_q, iproto_q;
  logic [4:0]  ghl_q;
  logic [15:0] gtype_q;
  logic [31:0] src_q, dst_q, ports_q, seq_q;

  logic [17:0] off, g, ib, t;
  logic [5:0]  ohl_n, ihl_n;
  logic [4:0]  ghl_n;
  logic [7:0]  oproto_n, iproto_n;
  logic [15:0] gtype_n;
  logic [31:0] src_n, dst_n, ports_n, seq_n;
  logic [17:0] len;
  kind_e       kind;
  logic        take;

  assign in_ready_o = ~sum_valid_o | sum_ready_i;
  assign take = in_valid_i & in_ready_o;
  assign off = {2'b0, off_q};

  // Field capture, same offsets as the header walk
  always_comb begin
    ohl_n = ohl_q; oproto_n = oproto_q; ghl_n = ghl_q; gtype_n = gtype_q;
    ihl_n = ihl_q; iproto_n = iproto_q; src_n = src_q; dst_n = dst_q;
    ports_n = ports_q; seq_n = seq_q;
    g = 18'd14 + {12'd0, ohl_n};
    ib = '0;
    t = '0;
    if (off == 18'd14) ohl_n = {byte_i[3:0], 2'b00};
    if (off == 18'd23) oproto_n = byte_i;
    g = 18'd14 + {12'd0, ohl_n};
    if (ohl_n >= 6'd20) begin
      if (off == g)
        ghl_n = 5'd4 + {1'b0, 2'b0, 2'b0} + ({3'd0, 2'(byte_i[7]) + 2'(byte_i[5])
                + 2'(byte_i[4])} << 2);
      if (off == g + 18'd2) gtype_n = {byte_i, gtype_n[7:0]};
      if (off == g + 18'd3) gtype_n = {gtype_n[15:8], byte_i};
      if (ghl_n != 5'd0) begin
        ib = g + {13'd0, ghl_n} + 18'd14;
        if (off == ib) ihl_n = {byte_i[3:0], 2'b00};
        if (off == ib + 18'd9) iproto_n = byte_i;
        if (off >= ib + 18'd12 && off < ib + 18'd16) src_n = {src_n[23:0], byte_i};
        if (off >= ib + 18'd16 && off < ib + 18'd20) dst_n = {dst_n[23:0], byte_i};
        if (ihl_n >= 6'd20) begin
          t = ib + {12'd0, ihl_n};
          if (off >= t && off < t + 18'd4) ports_n = {ports_n[23:0], byte_i};
          if (off >= t + 18'd4 && off < t + 18'd8) seq_n = {seq_n[23:0], byte_i};
        end
      end
    end
  end

  // Decision on the last byte
  always_comb begin
    len = off + 18'd1;
    kind = KIND_OTHER;
    if (len < 18'd24 || ohl_n < 6'd20 || oproto_n != ProtoGre) kind = KIND_DROP;
    else if (len < g + 18'd4) kind = KIND_DROP;
    else if (gtype_n != TypeErspan) kind = KIND_NOTSPAN;
    else if (len < g + {13'd0, ghl_n} + 18'd34) kind = KIND_DROP;
    else if (iproto_n == ProtoTcp) begin
      if (ihl_n < 6'd20 ||
          len < g + {13'd0, ghl_n} + 18'd14 + {12'd0, ihl_n} + 18'd8) kind = KIND_DROP;
      else kind = KIND_TCP;
    end else if (iproto_n == ProtoIcmp) kind = KIND_ICMP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; ohl_q <= '0; oproto_q <= '0; ghl_q <= '0; gtype_q <= '0;
      ihl_q <= '0; iproto_q <= '0; src_q <= '0; dst_q <= '0; ports_q <= '0;
      seq_q <= '0; sum_valid_o <= 1'b0;
    end else begin
      if (take && last_i) sum_valid_o <= 1'b1;
      else if (sum_ready_i) sum_valid_o <= 1'b0;
      if (take) begin
        if (last_i) begin
          off_q <= '0; ohl_q <= '0; oproto_q <= '0; ghl_q <= '0; gtype_q <= '0;
          ihl_q <= '0; iproto_q <= '0; src_q <= '0; dst_q <= '0; ports_q <= '0;
          seq_q <= '0;
        end else begin
          if (off_q != 16'hFFFF) off_q <= off_q + 16'd1;
          ohl_q <= ohl_n; oproto_q <= oproto_n; ghl_q <= ghl_n; gtype_q <= gtype_n;
          ihl_q <= ihl_n; iproto_q <= iproto_n; src_q <= src_n; dst_q <= dst_n;
          ports_q <= ports_n; seq_q <= seq_n;
        end
      end
    end
  end

  // Summary register; the hash multiply sits here, the modulo in the back end
  always_ff @(posedge clk_i) begin
    if (take && last_i) begin
      sum_o.kind  <= kind;
      sum_o.proto <= iproto_n;
      sum_o.src   <= src_n;
      sum_o.dst   <= dst_n;
      sum_o.hash  <= (src_n * HashMul) ^ dst_n ^ {16'd0, ports_n[31:16]} ^
                     {16'd0, ports_n[15:0]} ^ seq_n;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/efc_back.sv @@
// Back end: queue modulo, rule matching, hit counters and output register.
`timescale 1ns / 1ps
`default_nettype none
module efc_back
  import efc_pkg::*;
#(
  parameter int NumRules  = NumRulesDef,
  parameter int MaxQueues = MaxQueuesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        sum_valid_i,
  output logic             sum_ready_o,
  input  pkt_sum_t         sum_i,
  input  wire logic [4:0]  num_queues_i,
  input  wire logic [1:0]  rules_i,
  input  wire logic [63:0] rsrc_i,
  input  wire logic [63:0] rdst_i,
  input  wire logic [17:0] rproto_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [3:0]       queue_o,
  output logic [1:0]       hits_o,
  output logic [31:0]      cnt0_o,
  output logic [31:0]      cnt1_o
);
  be_state_e   state_q, state_d;
  pkt_sum_t    pkt_q;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  bit_q, bit_d;
  logic [4:0]  nq;
  logic [31:0] cnt_q [2];
  logic [1:0]  hit;
  logic [1:0]  active;
  logic [5:0]  trial;

  always_comb begin
    nq = num_queues_i;
    if (nq > 5'(MaxQueues)) nq = 5'(MaxQueues);
    if (nq == 5'd0) nq = 5'd1;
    active = rules_i;
    if (active > 2'(NumRules)) active = 2'(NumRules);
  end

  always_comb begin
    hit = '0;
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < active && pkt_q.kind != KIND_NOTSPAN && pkt_q.kind != KIND_DROP &&
          (rsrc_i[32*i +: 32] == 32'd0 || rsrc_i[32*i +: 32] == pkt_q.src) &&
          (rdst_i[32*i +: 32] == 32'd0 || rdst_i[32*i +: 32] == pkt_q.dst) &&
          (rproto_i[9*i +: 9] == ProtoAny || rproto_i[9*i +: 9] == {1'b0, pkt_q.proto}))
        hit[i] = 1'b1;
    end
  end

  // Restoring modulo, one dividend bit per cycle into a 5-bit partial remainder
  always_comb begin
    state_d = state_q;
    rem_d = rem_q;
    bit_d = bit_q;
    trial = {rem_q[4:0], pkt_q.hash[bit_q[4:0]]};
    case (state_q)
      BE_IDLE: begin
        if (sum_valid_i) begin
          state_d = (sum_i.kind == KIND_TCP) ? BE_MOD : BE_OUT;
          rem_d = '0;
          bit_d = 6'd31;
        end
      end
      BE_MOD: begin
        rem_d = (trial >= {1'b0, nq}) ? 32'(trial - {1'b0, nq}) : 32'(trial);
        if (bit_q == 6'd0) state_d = BE_OUT;
        else bit_d = bit_q - 6'd1;
      end
      BE_OUT: begin
        if (~out_valid_o | out_ready_i) state_d = BE_IDLE;
      end
      default: state_d = BE_IDLE;
    endcase
  end

  always_comb sum_ready_o = (state_q == BE_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      out_valid_o <= 1'b0;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BE_OUT && (~out_valid_o | out_ready_i)) begin
        out_valid_o <= 1'b1;
        if (hit[0]) cnt_q[0] <= cnt_q[0] + 32'd1;
        if (hit[1]) cnt_q[1] <= cnt_q[1] + 32'd1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    bit_q <= bit_d;
    if (state_q == BE_IDLE && sum_valid_i) pkt_q <= sum_i;
    if (state_q == BE_OUT && (~out_valid_o | out_ready_i)) begin
      kind_o  <= pkt_q.kind;
      queue_o <= (pkt_q.kind == KIND_TCP) ? rem_q[3:0] : 4'd0;
      hits_o  <= hit;
      cnt0_o  <= cnt_q[0] + {31'd0, hit[0]};
      cnt1_o  <= cnt_q[1] + {31'd0, hit[1]};
    end
  end
endmodule
`default_nettype wire

@@ verif/efc_checker.sv @@
// Checker for the ERSPAN flow classifier: predicts results from accepted beats and compares.
`timescale 1ns / 1ps
module efc_checker
  import efc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [79:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output int               pending_o,
  output int               fails_o
);
  typedef struct {
    kind_e       kind;
    logic [3:0]  queue;
    logic [1:0]  hits;
    logic [31:0] cnt0;
    logic [31:0] cnt1;
  } verdict_t;

  verdict_t verdict_q[$];

  // configuration copy
  int unsigned nq_cfg, rules_cfg;
  logic [31:0] rsrc [2];
  logic [31:0] rdst [2];
  logic [8:0]  rproto [2];

  // per-frame parse state
  int unsigned offset, ohl, oproto, ghl, gtype, ihl, iproto;
  logic [31:0] isrc, idst, ports, seq;
  logic [31:0] hit_cnt [2];

  assign pending_o = verdict_q.size();

  task automatic clear_frame();
    offset = 0; ohl = 0; oproto = 0; ghl = 0; gtype = 0; ihl = 0; iproto = 0;
    isrc = '0; idst = '0; ports = '0; seq = '0;
  endtask

  task automatic parse_byte(int unsigned off, logic [7:0] b);
    int unsigned g, ib, t;
    if (off == 14) ohl = b[3:0] * 4;
    if (off == 23) oproto = b;
    if (ohl < 20) return;
    g = 14 + ohl;
    if (off == g) ghl = 4 + 4 * (b[7] + b[5] + b[4]);
    if (off == g + 2) gtype = (gtype & 'hFF) | (b << 8);
    if (off == g + 3) gtype = (gtype & 'hFF00) | b;
    if (ghl == 0) return;
    ib = g + ghl + 14;
    if (off == ib) ihl = b[3:0] * 4;
    if (off == ib + 9) iproto = b;
    if (off >= ib + 12 && off < ib + 16) isrc = {isrc[23:0], b};
    if (off >= ib + 16 && off < ib + 20) idst = {idst[23:0], b};
    if (ihl < 20) return;
    t = ib + ihl;
    if (off >= t && off < t + 4) ports = {ports[23:0], b};
    if (off >= t + 4 && off < t + 8) seq = {seq[23:0], b};
  endtask

  function automatic kind_e classify(int unsigned len);
    int unsigned g, ib;
    if (len < 24 || ohl < 20 || oproto != ProtoGre) return KIND_DROP;
    g = 14 + ohl;
    if (len < g + 4) return KIND_DROP;
    if (gtype != TypeErspan) return KIND_NOTSPAN;
    ib = g + ghl + 14;
    if (len < ib + 20) return KIND_DROP;
    if (iproto == ProtoTcp) begin
      if (ihl < 20 || len < ib + ihl + 8) return KIND_DROP;
      return KIND_TCP;
    end
    return (iproto == ProtoIcmp) ? KIND_ICMP : KIND_OTHER;
  endfunction

  task automatic predict_verdict(int unsigned len);
    verdict_t v;
    int unsigned nq, active;
    logic [31:0] h;
    v.kind = classify(len);
    v.queue = '0;
    v.hits = '0;
    if (v.kind == KIND_TCP) begin
      nq = (nq_cfg > 16) ? 16 : (nq_cfg == 0 ? 1 : nq_cfg);
      h = (isrc * HashMul) ^ idst ^ {16'd0, ports[31:16]} ^ {16'd0, ports[15:0]} ^ seq;
      v.queue = h % nq;
    end
    if (v.kind inside {KIND_TCP, KIND_ICMP, KIND_OTHER}) begin
      active = (rules_cfg > 2) ? 2 : rules_cfg;
      for (int i = 0; i < active; i++) begin
        if (rsrc[i] != 0 && rsrc[i] != isrc) continue;
        if (rdst[i] != 0 && rdst[i] != idst) continue;
        if (rproto[i] != ProtoAny && rproto[i] != {1'b0, iproto[7:0]}) continue;
        hit_cnt[i] = hit_cnt[i] + 1;
        v.hits[i] = 1'b1;
      end
    end
    v.cnt0 = hit_cnt[0];
    v.cnt1 = hit_cnt[1];
    verdict_q.push_back(v);
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    int unsigned off;
    if (!rst_ni) begin
      nq_cfg = 1; rules_cfg = 0;
      for (int i = 0; i < 2; i++) begin
        rsrc[i] = '0; rdst[i] = '0; rproto[i] = ProtoAny; hit_cnt[i] = '0;
      end
      clear_frame();
      verdict_q.delete();
      fails_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM_QUEUES: nq_cfg = cfg_data_i[4:0];
          REG_RULES:      rules_cfg = cfg_data_i[1:0];
          REG_R0_SRC:     rsrc[0] = cfg_data_i;
          REG_R0_DST:     rdst[0] = cfg_data_i;
          REG_R0_PROTO:   rproto[0] = cfg_data_i[8:0];
          REG_R1_SRC:     rsrc[1] = cfg_data_i;
          REG_R1_DST:     rdst[1] = cfg_data_i;
          REG_R1_PROTO:   rproto[1] = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no expectation: %0h", m_axis_tdata);
          fails_o++;
        end else begin
          v = verdict_q.pop_front();
          compare_field("packet_kind", v.kind, m_axis_tdata[2:0]);
          compare_field("queue_index", v.queue, m_axis_tdata[6:3]);
          compare_field("rule_hits", v.hits, m_axis_tdata[8:7]);
          compare_field("rule0_count", v.cnt0, m_axis_tdata[40:9]);
          compare_field("rule1_count", v.cnt1, m_axis_tdata[72:41]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        off = offset;
        parse_byte(off, s_axis_tdata);
        if (s_axis_tlast) begin
          predict_verdict(off + 1);
          clear_frame();
        end else if (offset < 65535) begin
          offset++;
        end
      end
    end
  end
endmodule

@@ verif/tb_erspan_flow_classifier.sv @@
// Testbench top for the ERSPAN flow classifier: frame stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_erspan_flow_classifier;
  import efc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          pending, fails;
  int unsigned cycles = 0;
  int          burst_left = 0;
  int unsigned bytes_sent = 0;
  logic        hold_req = 1'b0;
  logic [7:0]  frame_q[$];
  logic [31:0] addr_pool [4] = '{32'h0A000001, 32'hC0A80101, 32'hFFFFFFFF, 32'h00000001};

  always #4 clk_i = ~clk_i;

  erspan_flow_classifier dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  efc_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .fails_o(fails)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1_500_000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: shifting stall patterns, plus one long hold-off to back the block up
  initial begin
    int rcyc, mode, hold_left;
    bit held;
    rcyc = 0;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      rcyc++;
      if (rcyc % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_req && !held) begin
        held = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Send one beat; called at a falling edge, returns at a falling edge
  task automatic send_beat(logic [7:0] b, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    @(negedge clk_i);
    foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    bytes_sent += frame_q.size();
  endtask

  function automatic logic [31:0] pick_addr();
    return ($urandom_range(0, 2) == 0) ? $urandom() : addr_pool[$urandom_range(0, 3)];
  endfunction

  // Assemble a frame; cut = 0 keeps it whole, else truncates to cut bytes if that is shorter
  task automatic build_frame(logic [3:0] oihl, logic [7:0] oproto, logic [7:0] gflags,
                             logic [15:0] gtype, logic [3:0] iihl, logic [7:0] iproto,
                             int tail, int cut);
    logic [31:0] src, dst;
    int olen, ilen, nopt;
    src = pick_addr();
    dst = pick_addr();
    olen = (oihl < 5) ? 20 : oihl * 4;
    ilen = (iihl < 5) ? 20 : iihl * 4;
    nopt = 4 * (gflags[7] + gflags[5] + gflags[4]);
    frame_q.delete();
    repeat (14) frame_q.push_back($urandom());
    frame_q.push_back({4'h4, oihl});
    for (int i = 1; i < olen; i++) frame_q.push_back(i == 9 ? oproto : 8'($urandom()));
    frame_q.push_back(gflags);
    frame_q.push_back($urandom());
    frame_q.push_back(gtype[15:8]);
    frame_q.push_back(gtype[7:0]);
    repeat (nopt) frame_q.push_back($urandom());
    repeat (14) frame_q.push_back($urandom());
    frame_q.push_back({4'h4, iihl});
    for (int i = 1; i < ilen; i++) begin
      if (i == 9) frame_q.push_back(iproto);
      else if (i >= 12 && i < 16) frame_q.push_back(src[8 * (15 - i) +: 8]);
      else if (i >= 16 && i < 20) frame_q.push_back(dst[8 * (19 - i) +: 8]);
      else frame_q.push_back($urandom());
    end
    repeat (8 + tail) frame_q.push_back($urandom());
    if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0:cut - 1];
  endtask

  task automatic good_frame(logic [7:0] iproto, int cut);
    build_frame(($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5, ProtoGre,
                $urandom(), TypeErspan,
                ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5,
                iproto, $urandom_range(0, 12), cut);
  endtask

  task automatic random_frame();
    int r;
    logic [7:0] ip;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0, 1, 2: ip = ProtoTcp;
      3: ip = ProtoIcmp;
      4: ip = 8'd17;
      default: ip = $urandom();
    endcase
    if (r < 60) good_frame(ip, 0);
    else if (r < 75) good_frame(ip, $urandom_range(1, 90));
    else if (r < 80) build_frame(5, $urandom(), $urandom(), TypeErspan, 5, ip, 4, 0);
    else if (r < 85) build_frame(5, ProtoGre, $urandom(), $urandom(), 5, ip, 4, 0);
    else if (r < 90) build_frame($urandom_range(0, 4), ProtoGre, $urandom(), TypeErspan, 5, ip,
                                 4, 0);
    else if (r < 93) build_frame(5, ProtoGre, $urandom(), TypeErspan, $urandom_range(0, 4),
                                 ip, 4, 0);
    else begin
      frame_q.delete();
      repeat ($urandom_range(1, 40)) frame_q.push_back($urandom());
    end
    send_frame();
  endtask

  task automatic random_config();
    write_reg(REG_NUM_QUEUES, $urandom_range(0, 31));
    write_reg(REG_RULES, $urandom_range(0, 3));
    write_reg(REG_R0_SRC, ($urandom_range(0, 1) == 0) ? 32'd0 : addr_pool[$urandom_range(0, 3)]);
    write_reg(REG_R0_DST, ($urandom_range(0, 1) == 0) ? 32'd0 : addr_pool[$urandom_range(0, 3)]);
    write_reg(REG_R0_PROTO, ($urandom_range(0, 1) == 0) ? ProtoAny : 9'($urandom_range(0, 511)));
    write_reg(REG_R1_SRC, ($urandom_range(0, 1) == 0) ? 32'd0 : addr_pool[$urandom_range(0, 3)]);
    write_reg(REG_R1_DST, ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom());
    write_reg(REG_R1_PROTO, ($urandom_range(0, 1) == 0) ? ProtoAny : {1'b0, ProtoTcp});
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: defaults, every kind, drop causes and truncation points
    good_frame(ProtoTcp, 0); send_frame();
    good_frame(ProtoIcmp, 0); send_frame();
    drain();
    write_reg(REG_NUM_QUEUES, 16);
    write_reg(REG_RULES, 2);
    write_reg(REG_R0_SRC, addr_pool[0]);
    write_reg(REG_R0_DST, 32'd0);
    write_reg(REG_R0_PROTO, ProtoAny);
    write_reg(REG_R1_SRC, 32'd0);
    write_reg(REG_R1_DST, 32'd0);
    write_reg(REG_R1_PROTO, {1'b0, ProtoTcp});
    good_frame(ProtoTcp, 0); send_frame();
    good_frame(8'd17, 0); send_frame();
    good_frame(8'hFF, 0); send_frame();
    build_frame(15, ProtoGre, 8'hFF, TypeErspan, 15, ProtoTcp, 0, 0); send_frame();
    build_frame(5, 8'd0, 8'h00, TypeErspan, 5, ProtoTcp, 0, 0); send_frame();
    build_frame(5, ProtoGre, 8'h00, 16'h0800, 5, ProtoTcp, 0, 0); send_frame();
    build_frame(4, ProtoGre, 8'h00, TypeErspan, 5, ProtoTcp, 0, 0); send_frame();
    build_frame(5, ProtoGre, 8'h00, TypeErspan, 3, ProtoTcp, 0, 0); send_frame();
    build_frame(5, ProtoGre, 8'h00, TypeErspan, 0, ProtoIcmp, 0, 0); send_frame();
    foreach (frame_q[i]) frame_q[i] = 8'h00;
    frame_q = '{8'hFF}; send_frame();
    good_frame(ProtoTcp, 23); send_frame();
    good_frame(ProtoTcp, 24); send_frame();
    build_frame(5, ProtoGre, 8'h00, TypeErspan, 5, ProtoTcp, 0, 37); send_frame();
    build_frame(5, ProtoGre, 8'h00, TypeErspan, 5, ProtoTcp, 0, 71); send_frame();
    build_frame(5, ProtoGre, 8'h00, TypeErspan, 5, ProtoTcp, 0, 79); send_frame();
    build_frame(5, ProtoGre, 8'h00, TypeErspan, 5, ProtoTcp, 0, 80); send_frame();
    drain();
    write_reg(REG_NUM_QUEUES, 0);
    write_reg(REG_RULES, 3);
    write_reg(REG_R0_PROTO, 9'd300);
    write_reg(REG_R1_DST, addr_pool[2]);
    write_reg(REG_R1_PROTO, ProtoAny);
    good_frame(ProtoTcp, 0); send_frame();
    good_frame(ProtoIcmp, 0); send_frame();
    drain();
    write_reg(REG_NUM_QUEUES, 31);
    good_frame(ProtoTcp, 0); send_frame();
    drain();

    // Random phases, each under a fresh configuration; the first backs the block up
    hold_req = 1'b1;
    do begin
      random_config();
      repeat (12) random_frame();
      drain();
    end while (bytes_sent < 1100);

    drain();
    repeat (40) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
